/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bsa_pkg.sv */
// Types, constants and helpers of the bitmap slot allocator.
`default_nettype none

package bsa_pkg;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 9;
    localparam int IDX_W     = 8;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Bitmap storage word
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    // Parameter defaults
    localparam int DEF_MAX_POOL_SLOTS = 256;
    localparam int DEF_SLOT_SHIFT     = 12;

    // Register reset values
    localparam logic [ADDR_W-1:0] RST_POOL_BASE  = '0;
    localparam logic [CNT_W-1:0]  RST_INIT_SLOTS = 9'd64;
    localparam logic [CNT_W-1:0]  RST_MAX_SLOTS  = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SLOTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOTS  = 2'd2;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EXHAUSTED = 3'd1,
        STAT_NULL      = 3'd2,
        STAT_RANGE     = 3'd3,
        STAT_FREE      = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GROW,
        ST_SCAN,
        ST_FCHK,
        ST_FBIT,
        ST_OUT
    } t_state;

    // Effective slot count: zero acts as one, values above the map clamp to it
    function automatic logic [CNT_W-1:0] eff_slots(input logic [CNT_W-1:0] v,
                                                   input int unsigned lim);
        if (v == '0) begin
            return CNT_W'(1);
        end
        if (32'(v) > lim) begin
            return CNT_W'(lim);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bsa_if.sv */
// Handshake interfaces of the slot allocator: request, result and config write.
`default_nettype none

interface bsa_req_if
    import bsa_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

interface bsa_rsp_if
    import bsa_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] slot_address;
    logic [IDX_W-1:0]  slot_index;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  pool_capacity;

    modport source (output valid, output status, output slot_address, output slot_index,
                    output used_count, output pool_capacity, input ready);
    modport sink   (input valid, input status, input slot_address, input slot_index,
                    input used_count, input pool_capacity, output ready);
endinterface

interface bsa_cfg_if
    import bsa_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bitmap_slot_allocator_core.sv */
// Bitmap slot allocator: first-fit slot allocation over a word-organized used map.
//
//  Channel  Dir  Modport  Carries
//  i_cfg    in   sink     register index, write data (always ready)
//  i_req    in   sink     command, address
//  o_rsp    out  source   status, slot_address, slot_index, used_count, pool_capacity
//
//  Alloc: after accept a grow step, then a scan that reads map words in turn through
//  the single map read port until the first free slot is found, at most
//  ceil(capacity / 32) words. An alloc that finds the pool full at its maximum skips the scan.
//  Free: range check and word read, bit update, result; no bit update when a check fails.
//  After reset a clearing pass writes ceil(MAX_POOL_SLOTS / 32) map words, one per
//  cycle, before the first item is accepted; config writes are taken throughout.
//  A waiting result holds in the output register; a finished item waits in ST_OUT.
`default_nettype none
`include "assert_macros.svh"

module bitmap_slot_allocator_core
    import bsa_pkg::*;
#(
    parameter int MAX_POOL_SLOTS = DEF_MAX_POOL_SLOTS,
    parameter int SLOT_SHIFT     = DEF_SLOT_SHIFT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_cfg_if.sink   i_cfg,
    bsa_req_if.sink   i_req,
    bsa_rsp_if.source o_rsp
);

    localparam int DEPTH  = (MAX_POOL_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WA     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = WA + WORD_SH;
    localparam int IW     = (SLOT_W > CNT_W + 1) ? SLOT_W : CNT_W + 1;

    // Sequencer and control state
    t_state n_state;
    t_state r_state;

    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_maxs;
    logic [CNT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_cap;
    logic [WA-1:0]     r_clr;

    // Item work registers
    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [SLOT_W-1:0] r_slot;
    t_status           r_status;
    logic [WA-1:0]     r_scan_rd;
    logic [WA-1:0]     r_q_word;
    logic              r_q_vld;
    logic [WORD_W-1:0] r_q;

    // Used map
    logic [WORD_W-1:0] r_map [0:DEPTH-1];

    // Output register
    logic              r_out_vld;
    t_status           r_rsp_status;
    logic [ADDR_W-1:0] r_rsp_addr;
    logic [IDX_W-1:0]  r_rsp_idx;
    logic [CNT_W-1:0]  r_rsp_used;
    logic [CNT_W-1:0]  r_rsp_cap;

    // Combinational signals
    logic [CNT_W-1:0]  maxc;
    logic [CNT_W:0]    grown;
    logic [CNT_W-1:0]  cap_grown;
    logic              need_grow;
    logic              at_max;
    logic [WA-1:0]     last_word;
    logic [WORD_W-1:0] lim_mask;
    logic [WORD_W-1:0] free_bits;
    logic              hit;
    logic [WORD_SH-1:0] enc;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] fslot;
    logic              is_null;
    logic              is_below;
    logic              is_beyond;
    logic              fbit;
    logic              out_free;
    logic              mem_we;
    logic [WA-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic [WA-1:0]     rd_addr;

    // Capacity growth
    assign maxc      = eff_slots(r_maxs, MAX_POOL_SLOTS);
    assign grown     = {r_cap, 1'b0};
    assign cap_grown = (grown > {1'b0, maxc}) ? maxc : grown[CNT_W-1:0];
    assign need_grow = (r_total >= r_cap);
    assign at_max    = (r_cap >= maxc);
    assign last_word = WA'((r_cap - CNT_W'(1)) >> WORD_SH);

    // Mask the read word to slots below capacity and find its lowest free slot
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            lim_mask[j] = (IW'({r_q_word, WORD_SH'(j)}) < IW'(r_cap));
        end
    end

    assign free_bits = ~r_q & lim_mask;
    assign hit       = |free_bits;

    always_comb begin
        enc = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                enc = WORD_SH'(j);
            end
        end
    end

    // Free address checks
    assign diff      = r_addr - r_base;
    assign fslot     = diff >> SLOT_SHIFT;
    assign is_null   = (r_addr == '0);
    assign is_below  = (r_addr < r_base);
    assign is_beyond = (fslot >= 32'(r_cap)) || (fslot >= 32'(MAX_POOL_SLOTS));
    assign fbit      = r_q[r_slot[WORD_SH-1:0]];

    assign out_free  = !r_out_vld || o_rsp.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == WA'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.command == CMD_FREE) ? ST_FCHK : ST_GROW;
                end
            end
            ST_GROW: begin
                n_state = (need_grow && at_max) ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_q_vld && (hit || r_q_word == last_word)) begin
                    n_state = ST_OUT;
                end
            end
            ST_FCHK: begin
                n_state = (is_null || is_below || is_beyond) ? ST_OUT : ST_FBIT;
            end
            ST_FBIT: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Map port control per state
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_q_word;
        mem_wd  = r_q;
        rd_addr = r_scan_rd;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
            end
            ST_SCAN: begin
                if (r_q_vld && hit) begin
                    mem_we = 1'b1;
                    mem_wa = r_q_word;
                    mem_wd = r_q | (WORD_W'(1) << enc);
                end
            end
            ST_FCHK: begin
                rd_addr = fslot[WORD_SH +: WA];
            end
            ST_FBIT: begin
                if (fbit) begin
                    mem_we = 1'b1;
                    mem_wa = r_slot[SLOT_W-1:WORD_SH];
                    mem_wd = r_q & ~(WORD_W'(1) << r_slot[WORD_SH-1:0]);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sweep the map clear after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr <= r_clr + WA'(1);
        end
    end

    // Config registers, allocation count and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_POOL_BASE;
            r_maxs  <= RST_MAX_SLOTS;
            r_total <= '0;
            r_cap   <= eff_slots(RST_INIT_SLOTS, MAX_POOL_SLOTS);
        end else begin
            if (r_state == ST_SCAN && r_q_vld && hit) begin
                r_total <= r_total + CNT_W'(1);
            end
            if (r_state == ST_FBIT && fbit && r_total != '0) begin
                r_total <= r_total - CNT_W'(1);
            end
            // a write of the initial size reloads the capacity
            if (i_cfg.valid && i_cfg.index == REG_INIT_SLOTS) begin
                r_cap <= eff_slots(i_cfg.data[CNT_W-1:0], MAX_POOL_SLOTS);
            end else if (r_state == ST_GROW && need_grow && !at_max) begin
                r_cap <= cap_grown;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_POOL_BASE: begin
                        r_base <= i_cfg.data;
                    end
                    REG_MAX_SLOTS: begin
                        r_maxs <= i_cfg.data[CNT_W-1:0];
                    end
                    default: begin
                        r_base <= r_base;
                    end
                endcase
            end
        end
    end

    // Item work registers: latch the request, walk the map, record the outcome
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd  <= i_req.command;
                r_addr <= i_req.address;
            end
            ST_GROW: begin
                r_scan_rd <= '0;
                r_q_vld   <= 1'b0;
                r_slot    <= '0;
                r_status  <= STAT_EXHAUSTED;
            end
            ST_SCAN: begin
                r_q_word <= r_scan_rd;
                r_q_vld  <= 1'b1;
                if (r_scan_rd != last_word) begin
                    r_scan_rd <= r_scan_rd + WA'(1);
                end
                if (r_q_vld && hit) begin
                    r_slot   <= {r_q_word, enc};
                    r_status <= STAT_OK;
                end
            end
            ST_FCHK: begin
                if (is_null) begin
                    r_status <= STAT_NULL;
                    r_slot   <= '0;
                end else if (is_below || is_beyond) begin
                    r_status <= STAT_RANGE;
                    r_slot   <= '0;
                end else begin
                    r_slot <= SLOT_W'(fslot);
                end
            end
            ST_FBIT: begin
                r_status <= fbit ? STAT_OK : STAT_FREE;
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_q <= r_map[rd_addr];
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_rsp_status <= r_status;
            r_rsp_addr   <= (r_cmd == CMD_ALLOC && r_status == STAT_OK) ?
                            r_base + (ADDR_W'(r_slot) << SLOT_SHIFT) : '0;
            r_rsp_idx    <= IDX_W'(r_slot);
            r_rsp_used   <= r_total;
            r_rsp_cap    <= r_cap;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_rsp_status;
    assign o_rsp.slot_address  = r_rsp_addr;
    assign o_rsp.slot_index    = r_rsp_idx;
    assign o_rsp.used_count    = r_rsp_used;
    assign o_rsp.pool_capacity = r_rsp_cap;

    // Checks
    `ASSERT_NEXT(a_accept_leaves_idle, i_req.valid && i_req.ready, r_state != ST_IDLE, "item accepted but sequencer stayed idle")
    `ASSERT_IMPLY(a_rsp_from_out, $rose(o_rsp.valid), $past(r_state == ST_OUT), "result raised outside the result state")
    `ASSERT_IMPLY(a_free_count, r_state == ST_FBIT && fbit, r_total != '0, "used slot found while count is zero")
    `ASSERT_ALWAYS(a_cap_bound, (r_cap != '0) && (32'(r_cap) <= MAX_POOL_SLOTS), "capacity outside the map")

endmodule

`default_nettype wire

/* tb/bitmap_slot_allocator_core_checker.sv */
// Result checker for the bitmap slot allocator: tracks the pool and compares every result.
module bitmap_slot_allocator_core_checker
    import bsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bsa_cfg_if   i_cfg,
    bsa_req_if   i_req,
    bsa_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_waiting
);

    localparam int MAP_SLOTS = DEF_MAX_POOL_SLOTS;
    localparam int SHIFT     = DEF_SLOT_SHIFT;
    localparam int GROWTH    = 2;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] slot_address;
        logic [IDX_W-1:0]  slot_index;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  pool_capacity;
    } t_slot_result;

    // Register copies and pool state
    logic [ADDR_W-1:0]    base_addr;
    logic [CNT_W-1:0]     first_slots;
    logic [CNT_W-1:0]     limit_slots;
    logic [MAP_SLOTS-1:0] taken_map;
    logic [CNT_W-1:0]     taken_count;
    logic [CNT_W-1:0]     capacity;

    t_slot_result results_due[$];
    int mismatches = 0;
    int due_count  = 0;

    assign o_errors  = mismatches;
    assign o_waiting = due_count;

    // Zero counts as one slot, anything past the map as the whole map
    function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end
        if (v > CNT_W'(MAP_SLOTS)) begin
            return CNT_W'(MAP_SLOTS);
        end
        return v;
    endfunction

    // Apply one request to the pool and return the result it should give
    function automatic t_slot_result serve_request(input logic cmd,
                                                   input logic [ADDR_W-1:0] addr);
        t_slot_result r;
        logic [CNT_W-1:0]  ceiling;
        logic [CNT_W:0]    grown;
        logic [ADDR_W-1:0] offs;
        int                slot;
        bit                ok;
        bit                found;
        r       = '0;
        r.status = STAT_OK;
        ceiling = clamp_slots(limit_slots);
        slot    = 0;
        if (cmd == CMD_ALLOC) begin
            ok = 1'b1;
            // grow when full, fail when already at the ceiling
            if (taken_count >= capacity) begin
                if (capacity >= ceiling) begin
                    ok = 1'b0;
                end else begin
                    grown    = (CNT_W+1)'(capacity * GROWTH);
                    capacity = (grown > {1'b0, ceiling}) ? ceiling : grown[CNT_W-1:0];
                end
            end
            // first free slot below the capacity
            if (ok) begin
                found = 1'b0;
                for (int i = 0; i < MAP_SLOTS; i++) begin
                    if (!found && i < capacity && !taken_map[i]) begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (found) begin
                    taken_map[slot] = 1'b1;
                    taken_count     = taken_count + 1'b1;
                    r.slot_index    = IDX_W'(slot);
                    r.slot_address  = base_addr + (ADDR_W'(slot) << SHIFT);
                end else begin
                    ok = 1'b0;
                end
            end
            if (!ok) begin
                r.status = STAT_EXHAUSTED;
            end
        end else if (addr == '0) begin
            r.status = STAT_NULL;
        end else if (addr < base_addr) begin
            r.status = STAT_RANGE;
        end else begin
            // unaligned addresses land in the slot that holds them
            offs = (addr - base_addr) >> SHIFT;
            if (offs >= ADDR_W'(capacity) || offs >= ADDR_W'(MAP_SLOTS)) begin
                r.status = STAT_RANGE;
            end else if (!taken_map[offs]) begin
                r.status     = STAT_FREE;
                r.slot_index = IDX_W'(offs);
            end else begin
                taken_map[offs] = 1'b0;
                if (taken_count > 0) begin
                    taken_count = taken_count - 1'b1;
                end
                r.slot_index = IDX_W'(offs);
            end
        end
        r.used_count    = taken_count;
        r.pool_capacity = capacity;
        return r;
    endfunction

    // Print one mismatch line and count it
    task automatic report(input string what, input logic [ADDR_W-1:0] got,
                          input logic [ADDR_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // Watch all three channels at each edge
    always @(posedge i_clk) begin : watch
        t_slot_result want;
        if (!i_rst_n) begin
            base_addr   = RST_POOL_BASE;
            first_slots = RST_INIT_SLOTS;
            limit_slots = RST_MAX_SLOTS;
            taken_map   = '0;
            taken_count = '0;
            capacity    = clamp_slots(RST_INIT_SLOTS);
            results_due.delete();
        end else begin
            // compare first: a result always belongs to an older item
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    report("result with no request waiting, status", ADDR_W'(i_rsp.status), '0);
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.status !== want.status)
                        report("status", ADDR_W'(i_rsp.status), ADDR_W'(want.status));
                    if (i_rsp.slot_address !== want.slot_address)
                        report("slot_address", i_rsp.slot_address, want.slot_address);
                    if (i_rsp.slot_index !== want.slot_index)
                        report("slot_index", ADDR_W'(i_rsp.slot_index), ADDR_W'(want.slot_index));
                    if (i_rsp.used_count !== want.used_count)
                        report("used_count", ADDR_W'(i_rsp.used_count), ADDR_W'(want.used_count));
                    if (i_rsp.pool_capacity !== want.pool_capacity)
                        report("pool_capacity", ADDR_W'(i_rsp.pool_capacity),
                               ADDR_W'(want.pool_capacity));
                end
            end
            // register writes; unknown indexes drop
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_POOL_BASE: begin
                        base_addr = i_cfg.data;
                    end
                    REG_INIT_SLOTS: begin
                        first_slots = i_cfg.data[CNT_W-1:0];
                        capacity    = clamp_slots(first_slots);
                    end
                    REG_MAX_SLOTS: begin
                        limit_slots = i_cfg.data[CNT_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                results_due.push_back(serve_request(i_req.command, i_req.address));
            end
        end
        due_count = results_due.size();
    end

endmodule

/* tb/bitmap_slot_allocator_core_tb.sv */
// Testbench top for the bitmap slot allocator: stimulus, handshake pacing and verdict.
module bitmap_slot_allocator_core_tb;
    import bsa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 128;
    localparam int SLOT_BYTES  = 1 << DEF_SLOT_SHIFT;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_LIGHT} t_stall;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsa_cfg_if cfg_ch ();
    bsa_req_if req_ch ();
    bsa_rsp_if rsp_ch ();

    int fail_count;
    int left_open;
    int items_sent   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int free_span    = 64;
    logic [ADDR_W-1:0] pool_base = RST_POOL_BASE;

    bitmap_slot_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bitmap_slot_allocator_core_checker audit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_ch),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (fail_count),
        .o_waiting (left_open)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count results and guard against a hang
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
        end
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result side in stretches of changing style
    initial begin : rsp_stall
        t_stall style;
        int     span_left;
        int     tick;
        style     = STALL_NONE;
        span_left = 0;
        tick      = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (span_left == 0) begin
                style     = t_stall'($urandom_range(0, 3));
                span_left = $urandom_range(20, 120);
            end
            span_left = span_left - 1;
            tick      = tick + 1;
            case (style)
                STALL_NONE:   rsp_ch.ready <= 1'b1;
                STALL_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: rsp_ch.ready <= (tick % 8 == 0);
                default:      rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Send one item; close a burst with a random gap
    task automatic send_req(input logic cmd, input logic [ADDR_W-1:0] addr);
        int gap;
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent = items_sent + 1;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
        end
    endtask

    // Hold requests until every result is back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != items_sent) @(posedge i_clk);
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_POOL_BASE) begin
            pool_base = val;
        end
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Address near the live slots, sometimes unaligned, sometimes just past them
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int                slot;
        logic [ADDR_W-1:0] off;
        slot = $urandom_range(0, free_span + 1);
        off  = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, SLOT_BYTES - 1)) : '0;
        return pool_base + (ADDR_W'(slot) << DEF_SLOT_SHIFT) + off;
    endfunction

    // Mostly well-formed traffic, some null, wild and below-base frees
    task automatic run_phase(input int count, input int alloc_pct);
        int                roll;
        logic [ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
                send_req(CMD_ALLOC, ADDR_W'($urandom));
            end else if (roll < 92) begin
                send_req(CMD_FREE, pick_free_addr());
            end else begin
                case ($urandom_range(0, 2))
                    0:       addr = '0;
                    1:       addr = ADDR_W'($urandom);
                    default: addr = pool_base - ADDR_W'($urandom_range(1, SLOT_BYTES));
                endcase
                send_req(CMD_FREE, addr);
            end
        end
    endtask

    task automatic run_directed();
        // null, far past the pool and a never-used slot, on reset registers
        send_req(CMD_FREE, '0);
        send_req(CMD_FREE, 32'hFFFF_FFFF);
        send_req(CMD_FREE, 32'h0000_1000);
        send_req(CMD_ALLOC, '0);
        // small pool: grow once and fill it, then free a slot and take it again
        wait_idle();
        write_reg(REG_POOL_BASE, 32'h8000_0000);
        write_reg(REG_INIT_SLOTS, 32'd2);
        write_reg(REG_MAX_SLOTS, 32'd4);
        write_reg(REG_SPARE, CFG_DAT_W'($urandom));
        end_writes();
        repeat (4) send_req(CMD_ALLOC, ADDR_W'($urandom));
        send_req(CMD_FREE, 32'h0000_1000);
        send_req(CMD_FREE, pool_base + 32'h1234);
        send_req(CMD_FREE, pool_base + 32'h1234);
        send_req(CMD_FREE, pool_base + 32'h4000);
        send_req(CMD_ALLOC, '0);
        // shrink below slots still in use
        wait_idle();
        write_reg(REG_INIT_SLOTS, 32'd1);
        end_writes();
        send_req(CMD_FREE, pool_base + 32'h3000);
        send_req(CMD_ALLOC, '0);
        // zero in both size registers acts as one slot
        wait_idle();
        write_reg(REG_INIT_SLOTS, 32'd0);
        write_reg(REG_MAX_SLOTS, 32'd0);
        end_writes();
        send_req(CMD_ALLOC, '0);
        // sizes past the map clamp; slot addresses wrap past the top
        wait_idle();
        write_reg(REG_POOL_BASE, 32'hFFFF_F000);
        write_reg(REG_INIT_SLOTS, 32'd511);
        write_reg(REG_MAX_SLOTS, 32'd511);
        end_writes();
        send_req(CMD_ALLOC, '0);
        send_req(CMD_FREE, 32'h0000_3000);
        send_req(CMD_FREE, 32'hFFFF_FFFF);
        send_req(CMD_FREE, 32'hFFFF_F000);
    endtask

    task automatic run_random();
        logic [ADDR_W-1:0] base;
        logic [CNT_W-1:0]  first;
        logic [CNT_W-1:0]  ceiling;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    base = '0; first = 9'd1; ceiling = 9'd256;
                end
                1: begin
                    base = 32'hFFFF_FFFF; first = 9'd256; ceiling = 9'd256;
                end
                2: begin
                    base = 32'hFFFF_8000; first = 9'd0; ceiling = 9'd511;
                end
                3: begin
                    base = ADDR_W'($urandom) & 32'h7FFF_F000; first = 9'd16; ceiling = 9'd4;
                end
                4: begin
                    base = ADDR_W'($urandom); first = 9'd511; ceiling = 9'd0;
                end
                default: begin
                    base = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom) & 32'hFFFF_F000
                                                       : ADDR_W'($urandom);
                    first   = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 511))
                                                          : CNT_W'($urandom_range(1, 48));
                    ceiling = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 511))
                                                          : CNT_W'($urandom_range(1, 96));
                end
            endcase
            // size free addresses to the larger of the two sizes
            free_span = (first > ceiling) ? first : ceiling;
            if (free_span == 0) free_span = 1;
            if (free_span > DEF_MAX_POOL_SLOTS) free_span = DEF_MAX_POOL_SLOTS;
            wait_idle();
            write_reg(REG_POOL_BASE, base);
            write_reg(REG_MAX_SLOTS, (CFG_DAT_W'($urandom) & 32'hFFFF_FE00) | CFG_DAT_W'(ceiling));
            write_reg(REG_INIT_SLOTS, (CFG_DAT_W'($urandom) & 32'hFFFF_FE00) | CFG_DAT_W'(first));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_SPARE, CFG_DAT_W'($urandom));
            end
            end_writes();
            run_phase(PHASE_ITEMS, $urandom_range(35, 70));
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_POOL_BASE;
        cfg_ch.data    <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_ALLOC;
        req_ch.address <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        wait_idle();
        // let any stray result show up
        repeat (32) @(posedge i_clk);
        if (fail_count == 0 && left_open == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
